[hw/rtl/lr_pkg.sv]
`timescale 1ns / 1ps

package lr_pkg;

  // transaction kinds carried on the input tuser
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam int COLOR_BITS = 24;

  typedef logic [COLOR_BITS-1:0] color_t;

endpackage

[hw/rtl/line_rasterizer.sv]
`timescale 1ns / 1ps

// Bresenham line rasterizer covering all eight octants. A start transaction
// (tuser = OP_START) carries two endpoints and two colours; the block picks
// the major axis (x when |dy| <= |dx|, else y), walks it upward from the
// endpoint with the smaller major coordinate and returns that first pixel in
// first_color. Each advance transaction (tuser = OP_ADVANCE) returns the next
// pixel in rest_color, with tlast set on the final pixel of the line. An
// advance with no line in progress returns nothing; a start during a line
// drops the old line. Pipeline: an accepted transaction lands in an input
// register (endpoint differences are formed on the way in), then the setup
// or the error-term step runs and loads the result register; a new
// transaction is taken every cycle while the output is not held up. The
// start setup is the longest path: the magnitudes, the major-axis compare,
// then the error seed and the end-of-line compare. A result held up on the
// output stops the stage; an empty input register still takes one more
// transaction, after which s_axis_tready follows m_axis_tready directly.
module line_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  // input stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata, low bit up: x_start, y_start, x_end, y_end, first_color,
  // rest_color, zero padding to a whole byte
  input  logic [((4*COORD_BITS+2*lr_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: op
  input  logic s_axis_tuser,
  // output stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata, low bit up: pixel_x, pixel_y, pixel_color, zero padding
  output logic [((2*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tlast: last_pixel
  output logic m_axis_tlast
);
  import lr_pkg::*;

  localparam int CB       = COORD_BITS;
  localparam int ERR_BITS = COORD_BITS + 4;
  localparam int OUT_BITS = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;

  // input register (differences formed as the transaction is taken)
  logic                in_valid;
  logic                in_op;
  logic [CB-1:0]       in_x1, in_y1, in_x2, in_y2;
  logic [CB:0]         in_dx, in_dy;
  color_t              in_c1, in_c2;

  // line state
  logic signed [CB-1:0]       cur_x, cur_y, major_end;
  logic signed [ERR_BITS-1:0] error_term;
  logic [ERR_BITS-1:0]        inc_flat, inc_diag;
  logic                       same_sign;
  logic                       x_major;
  logic                       line_active;
  color_t                     held_color;

  // next values
  logic signed [CB-1:0]       cur_x_next, cur_y_next, major_end_next;
  logic signed [ERR_BITS-1:0] error_term_next;
  logic [ERR_BITS-1:0]        inc_flat_next, inc_diag_next;
  logic                       same_sign_next, x_major_next, line_active_next;
  color_t                     held_color_next, res_color;
  logic                       res_last, produce;

  // setup helpers
  logic [CB:0]     abs_dx, abs_dy, maj_abs, min_abs;
  logic            st_x_major, st_rev;
  logic [CB-1:0]   st_major;
  // step helpers
  logic            err_pos, take_diag;
  logic [CB-1:0]   maj_step, min_step, min_cur;

  logic out_free, fire;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_comb begin
    // setup for a start transaction
    abs_dx     = in_dx[CB] ? (~in_dx + 1'b1) : in_dx;
    abs_dy     = in_dy[CB] ? (~in_dy + 1'b1) : in_dy;
    st_x_major = abs_dy <= abs_dx;
    st_rev     = st_x_major ? in_dx[CB] : in_dy[CB];
    maj_abs    = st_x_major ? abs_dx : abs_dy;
    min_abs    = st_x_major ? abs_dy : abs_dx;

    // step for an advance transaction
    err_pos   = !error_term[ERR_BITS-1];
    take_diag = x_major ? err_pos : (err_pos && (error_term != '0));
    maj_step  = (x_major ? cur_x : cur_y) + CB'(1);
    min_cur   = x_major ? cur_y : cur_x;
    min_step  = same_sign ? (min_cur + CB'(1)) : (min_cur - CB'(1));
    st_major  = '0;

    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    major_end_next   = major_end;
    error_term_next  = error_term;
    inc_flat_next    = inc_flat;
    inc_diag_next    = inc_diag;
    same_sign_next   = same_sign;
    x_major_next     = x_major;
    line_active_next = line_active;
    held_color_next  = held_color;
    res_color        = held_color;
    res_last         = 1'b0;
    produce          = 1'b0;

    if (in_op == OP_START) begin
      produce         = 1'b1;
      cur_x_next      = st_rev ? in_x2 : in_x1;
      cur_y_next      = st_rev ? in_y2 : in_y1;
      major_end_next  = st_x_major ? (st_rev ? in_x1 : in_x2)
                                   : (st_rev ? in_y1 : in_y2);
      st_major        = st_x_major ? (st_rev ? in_x2 : in_x1)
                                   : (st_rev ? in_y2 : in_y1);
      inc_flat_next   = {2'b00, min_abs, 1'b0};
      inc_diag_next   = {2'b00, min_abs, 1'b0} - {2'b00, maj_abs, 1'b0};
      error_term_next = {2'b00, min_abs, 1'b0} - {3'b000, maj_abs};
      same_sign_next  = (in_dx[CB] == in_dy[CB]) && (in_dx != '0) && (in_dy != '0);
      x_major_next    = st_x_major;
      held_color_next = in_c2;
      res_color       = in_c1;
      res_last        = $signed(st_major) >= $signed(major_end_next);
      line_active_next = !res_last;
    end else if (line_active) begin
      produce         = 1'b1;
      error_term_next = error_term + (take_diag ? inc_diag : inc_flat);
      if (x_major) begin
        cur_x_next = maj_step;
        cur_y_next = take_diag ? min_step : cur_y;
      end else begin
        cur_y_next = maj_step;
        cur_x_next = take_diag ? min_step : cur_x;
      end
      res_last         = $signed(maj_step) >= major_end;
      line_active_next = !res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      line_active   <= 1'b0;
    end else begin
      // input register
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end

      // state update and result register
      if (fire) begin
        line_active <= line_active_next;
      end
      if (out_free) begin
        m_axis_tvalid <= fire && produce;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op <= s_axis_tuser;
      in_x1 <= s_axis_tdata[0*CB +: CB];
      in_y1 <= s_axis_tdata[1*CB +: CB];
      in_x2 <= s_axis_tdata[2*CB +: CB];
      in_y2 <= s_axis_tdata[3*CB +: CB];
      in_c1 <= s_axis_tdata[4*CB +: COLOR_BITS];
      in_c2 <= s_axis_tdata[4*CB+COLOR_BITS +: COLOR_BITS];
      in_dx <= {s_axis_tdata[3*CB-1], s_axis_tdata[2*CB +: CB]}
             - {s_axis_tdata[CB-1], s_axis_tdata[0 +: CB]};
      in_dy <= {s_axis_tdata[4*CB-1], s_axis_tdata[3*CB +: CB]}
             - {s_axis_tdata[2*CB-1], s_axis_tdata[CB +: CB]};
    end
    if (fire) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      major_end  <= major_end_next;
      error_term <= error_term_next;
      inc_flat   <= inc_flat_next;
      inc_diag   <= inc_diag_next;
      same_sign  <= same_sign_next;
      x_major    <= x_major_next;
      held_color <= held_color_next;
    end
    if (fire && produce) begin
      m_axis_tdata <= OUT_BITS'({res_color, cur_y_next, cur_x_next});
      m_axis_tlast <= res_last;
    end
  end

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // a line that is still running has pixels left on its major axis
  a_active_bounded: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (x_major ? (cur_x < major_end) : (cur_y < major_end)))
    else $error("active line already at its end");

  // the final pixel of a line leaves the block idle
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (fire && produce && res_last) |=> !line_active)
    else $error("line still active after its last pixel");

  // an advance with no line in progress loads no result
  a_idle_advance: assert property (@(posedge clk) disable iff (rst)
    (fire && (in_op == OP_ADVANCE) && !line_active) |=> !m_axis_tvalid)
    else $error("advance while idle produced a pixel");

endmodule
